// ===== design/jog_pkg.sv =====
// shared constants and types for the josephus order generator
// no dependencies; imported by jog_ring and josephus_order_generator_unit
`timescale 1ns / 1ps

package jog_pkg;

    // build size of the circle
    localparam int MAX_PEOPLE = 64;

    // cursor index width and count width (count reaches MAX_PEOPLE itself)
    localparam int IDX_W = $clog2(MAX_PEOPLE);
    localparam int CNT_W = $clog2(MAX_PEOPLE + 1);

    // configuration word width and a compare width that holds both
    localparam int CFG_W = 7;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PERSON_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd1;

    // output field width
    localparam int POS_W = 7;

    // control from the sequencer to the alive ring
    typedef struct packed {
        logic             load;      // refill positions 0..count-1 as alive
        logic [CNT_W-1:0] count;
        logic             kill;      // clear one alive bit
        logic [IDX_W-1:0] kill_idx;
    } t_ring_ctrl;

endpackage

// ===== design/jog_ring.sv =====
// alive mask of the circle with fill, kill and a single probe read
// depends on jog_pkg
`timescale 1ns / 1ps

module jog_ring
    import jog_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ring_ctrl       i_ctrl,
    input  logic [IDX_W-1:0] i_probe_idx,
    output logic             o_probe_alive
);

    logic [MAX_PEOPLE-1:0] r_alive;
    logic [MAX_PEOPLE-1:0] n_alive;

    always_comb begin
        n_alive = r_alive;
        if (i_ctrl.load) begin
            // thermometer fill from the count
            for (int i = 0; i < MAX_PEOPLE; i++) begin
                n_alive[i] = (CNT_W'(i) < i_ctrl.count);
            end
        end else if (i_ctrl.kill) begin
            n_alive[i_ctrl.kill_idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
        end else begin
            r_alive <= n_alive;
        end
    end

    assign o_probe_alive = r_alive[i_probe_idx];

endmodule

// ===== design/josephus_order_generator_unit.sv =====
// top level of the josephus order generator: config registers and step sequencer
// depends on jog_pkg and jog_ring
`timescale 1ns / 1ps

// Each accepted command (i_start high while o_busy is low) eliminates one position
// of the circle and returns it on o_position with o_last_flag, marked by a one-cycle
// o_done strobe; the receiver cannot stall, so the word must be taken in that cycle.
// A command with i_restart set, or any command after a finished order, first refills
// positions 1..person_count (zero read as one, capped at MAX_PEOPLE) and puts the
// cursor on position 1. Each command then makes m compare-subtract passes of the
// shared unit that reduce step_size-1 below the alive count (m <= 126, reached with one
// position left), probes s ring entries one per cycle to pass the skipped alive
// positions (under one lap, s <= 63), eliminates the cursor, and probes n entries
// to move the cursor onto the next alive position (n <= 63, none on the last one).
// The alive ring is read at one probe index per cycle, which sets the scan length.
// Configuration writes are always ready and take effect at the next command.

module josephus_order_generator_unit
    import jog_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_restart,
    // result channel
    output logic                 o_done,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_last_flag,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a command
    localparam logic [2:0] ST_MOD  = 3'd1;  // reduce skip modulo remaining
    localparam logic [2:0] ST_SCAN = 3'd2;  // pass skipped alive positions
    localparam logic [2:0] ST_ELIM = 3'd3;  // eliminate cursor, present word
    localparam logic [2:0] ST_NEXT = 3'd4;  // move cursor to next alive

    logic [2:0]       r_state,     n_state;
    logic [CNT_W-1:0] r_remaining, n_remaining;
    logic [IDX_W-1:0] r_cursor,    n_cursor;
    logic [CMP_W-1:0] r_skip,      n_skip;
    logic [CFG_W-1:0] r_person_count;
    logic [CFG_W-1:0] r_step_size;

    logic             accept;
    logic             new_order;
    logic [CMP_W-1:0] count_ext;
    logic [CNT_W-1:0] start_count;
    logic [CFG_W-1:0] step_eff;
    logic [CMP_W-1:0] skip_init;
    logic [CMP_W-1:0] rem_ext;
    logic [IDX_W-1:0] probe_idx;
    logic             probe_alive;
    t_ring_ctrl       ring_ctrl;

    // configuration registers, writes to unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_person_count <= CFG_W'(1);
            r_step_size    <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PERSON_COUNT: r_person_count <= i_cfg_data;
                REG_STEP_SIZE:    r_step_size    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // count of a new order: zero reads as one, saturate at build size
    assign count_ext = CMP_W'(r_person_count);

    always_comb begin
        priority if (count_ext == '0) begin
            start_count = CNT_W'(1);
        end else if (count_ext > CMP_W'(MAX_PEOPLE)) begin
            start_count = CNT_W'(MAX_PEOPLE);
        end else begin
            start_count = CNT_W'(count_ext);
        end
    end

    // step zero behaves like one
    assign step_eff  = (r_step_size == '0) ? CFG_W'(1) : r_step_size;
    assign skip_init = CMP_W'(step_eff - CFG_W'(1));

    assign accept    = i_start && !o_busy;
    assign new_order = i_restart || (r_remaining == '0);
    assign rem_ext   = CMP_W'(r_remaining);

    // next ring index after the cursor, with wraparound
    assign probe_idx = (r_cursor == IDX_W'(MAX_PEOPLE - 1)) ? '0 : r_cursor + IDX_W'(1);

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_cursor    = r_cursor;
        n_skip      = r_skip;
        ring_ctrl   = '{load: 1'b0, count: start_count, kill: 1'b0, kill_idx: r_cursor};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (new_order) begin
                        ring_ctrl.load = 1'b1;
                        n_remaining    = start_count;
                        n_cursor       = '0;
                    end
                    n_skip  = skip_init;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // shared compare-subtract unit, one pass per cycle
                if (r_skip >= rem_ext) begin
                    n_skip = r_skip - rem_ext;
                end else if (r_skip == '0) begin
                    n_state = ST_ELIM;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cursor = probe_idx;
                if (probe_alive) begin
                    n_skip = r_skip - CMP_W'(1);
                    if (r_skip == CMP_W'(1)) begin
                        n_state = ST_ELIM;
                    end
                end
            end
            ST_ELIM: begin
                ring_ctrl.kill = 1'b1;
                n_remaining    = r_remaining - CNT_W'(1);
                if (r_remaining == CNT_W'(1)) begin
                    n_cursor = '0;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                n_cursor = probe_idx;
                if (probe_alive) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_remaining <= '0;
            r_cursor    <= '0;
            r_skip      <= '0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_cursor    <= n_cursor;
            r_skip      <= n_skip;
        end
    end

    jog_ring u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ring_ctrl),
        .i_probe_idx   (probe_idx),
        .o_probe_alive (probe_alive)
    );

    // result word is shown for the single elimination cycle
    assign o_busy      = (r_state != ST_IDLE);
    assign o_done      = (r_state == ST_ELIM);
    assign o_position  = POS_W'(CNT_W'(r_cursor) + CNT_W'(1));
    assign o_last_flag = (r_state == ST_ELIM) && (r_remaining == CNT_W'(1));

    // a command always goes busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("accepted command did not raise busy");

    // alive count never exceeds the build size
    a_remaining_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= CNT_W'(MAX_PEOPLE))
        else $error("remaining count above build size");

    // the final word ends the order and parks the cursor
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_last_flag) |=> (r_remaining == '0 && r_cursor == '0 && !o_busy))
        else $error("order not closed after last word");

    // scanning always has at least one alive position left to pass
    a_scan_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_skip != '0 && r_skip < rem_ext))
        else $error("scan entered with an out-of-range skip");

endmodule

// ===== tb/josephus_order_generator_unit_checker.sv =====
// elimination-order checker for josephus_order_generator_unit
// depends on jog_pkg; watches the command, result and config channels of the block
`timescale 1ns / 1ps

module josephus_order_generator_unit_checker
    import jog_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic                 i_restart,
    input  logic                 i_done,
    input  logic [POS_W-1:0]     i_position,
    input  logic                 i_last_flag,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_flag;
    } t_elimination;

    t_elimination          expected_eliminations[$];

    // shadow of the circle and of the config registers
    logic [MAX_PEOPLE-1:0] alive;
    logic [IDX_W-1:0]      cursor_idx;
    int                    left_count;
    logic [CFG_W-1:0]      count_reg;
    logic [CFG_W-1:0]      stride_reg;

    int                    pending_count = 0;
    int                    error_count = 0;

    assign o_pending = pending_count;
    assign o_errors  = error_count;

    function automatic logic [IDX_W-1:0] next_alive_after(input logic [IDX_W-1:0] from,
                                                          input logic [MAX_PEOPLE-1:0] mask);
        int idx;
        for (int i = 1; i <= MAX_PEOPLE; i++) begin
            idx = (int'(from) + i) % MAX_PEOPLE;
            if (mask[idx])
                return IDX_W'(idx);
        end
        return from;
    endfunction

    task automatic fill_circle();
        int n;
        n = int'(count_reg);
        if (n == 0)
            n = 1;
        if (n > MAX_PEOPLE)
            n = MAX_PEOPLE;
        alive = '0;
        for (int i = 0; i < n; i++)
            alive[i] = 1'b1;
        cursor_idx = '0;
        left_count = n;
    endtask

    task automatic eliminate_next(input logic restart, output t_elimination res);
        int stride;
        int skip;
        if (restart || left_count == 0)
            fill_circle();
        stride = (stride_reg == '0) ? 1 : int'(stride_reg);
        skip = (stride - 1) % left_count;
        repeat (skip) cursor_idx = next_alive_after(cursor_idx, alive);
        res.position = POS_W'(int'(cursor_idx) + 1);
        alive[cursor_idx] = 1'b0;
        left_count--;
        res.last_flag = (left_count == 0);
        cursor_idx = (left_count != 0) ? next_alive_after(cursor_idx, alive) : '0;
    endtask

    always @(posedge i_clk) begin : watch
        t_elimination predicted;
        t_elimination oldest;
        if (!i_rst_n) begin
            count_reg  = CFG_W'(1);
            stride_reg = CFG_W'(1);
            alive      = '0;
            cursor_idx = '0;
            left_count = 0;
            expected_eliminations.delete();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    REG_PERSON_COUNT: count_reg = i_cfg_data;
                    REG_STEP_SIZE:    stride_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done === 1'b1) begin
                if (expected_eliminations.size() == 0) begin
                    $error("position: expected none, got %0d", i_position);
                    error_count++;
                end else begin
                    oldest = expected_eliminations.pop_front();
                    if (i_position !== oldest.position) begin
                        $error("position: expected %0d, got %0d", oldest.position, i_position);
                        error_count++;
                    end
                    if (i_last_flag !== oldest.last_flag) begin
                        $error("last_flag: expected %0b, got %0b", oldest.last_flag,
                               i_last_flag);
                        error_count++;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                eliminate_next(i_restart, predicted);
                expected_eliminations.push_back(predicted);
            end
        end
        pending_count <= expected_eliminations.size();
    end

endmodule

// ===== tb/josephus_order_generator_unit_tb.sv =====
// stimulus and verdict for josephus_order_generator_unit
// depends on jog_pkg, the block and josephus_order_generator_unit_checker
`timescale 1ns / 1ps

module josephus_order_generator_unit_tb;
    import jog_pkg::*;

    // indexes past the two real registers, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int ITEM_TARGET   = 2000;
    localparam int SETTLE_CYCLES = 250;
    localparam int LIMIT_NS      = 25_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 i_restart = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [POS_W-1:0]     o_position;
    logic                 o_last_flag;
    logic                 o_cfg_ready;
    int                   pending_words;
    int                   fail_count;

    int                   total_items = 0;

    always #5 i_clk = ~i_clk;

    josephus_order_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_restart   (i_restart),
        .o_done      (o_done),
        .o_position  (o_position),
        .o_last_flag (o_last_flag),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    josephus_order_generator_unit_checker order_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_restart   (i_restart),
        .i_done      (o_done),
        .i_position  (o_position),
        .i_last_flag (o_last_flag),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending_words),
        .o_errors    (fail_count)
    );

    // hold start low until every predicted word has come back and the block is idle
    // all tasks are entered and left on a rising edge
    task automatic pause_for_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0 || o_busy !== 1'b0);
        repeat (2) @(posedge i_clk);
    endtask

    // present one command, after a random gap, and wait for it to be taken
    // start stays high on return so back-to-back commands need no extra nba
    task automatic send_cmd(input logic restart, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        total_items++;
    endtask

    // valid is left high so consecutive writes do not toggle it within one step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    task automatic set_circle(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] stride);
        write_reg(REG_PERSON_COUNT, count);
        write_reg(REG_STEP_SIZE, stride);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly small circles and strides, with zero, the build size and
    // out-of-range values mixed in
    function automatic logic [CFG_W-1:0] pick_cfg_value();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return CFG_W'(MAX_PEOPLE);
            2:       return '1;
            3:       return CFG_W'($urandom_range(MAX_PEOPLE + 1, 126));
            4, 5, 6: return CFG_W'($urandom_range(1, MAX_PEOPLE));
            default: return CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    // registers change only between phases, so an order may run on with a new
    // stride or be restarted with a new count
    task automatic random_setting();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick != 2)
            write_reg(REG_PERSON_COUNT, pick_cfg_value());
        if (pick != 1)
            write_reg(REG_STEP_SIZE, pick_cfg_value());
        if (pick == 3)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_W'($urandom_range(0, 127)));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int phase;
        int phase_len;
        int idle_pct;
        logic restart;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one position, each command starts and ends an order
        send_cmd(1'b0, 0);
        send_cmd(1'b0, 0);

        // spare indexes are ignored, zero count and zero stride act as one
        pause_for_idle();
        write_reg(REG_SPARE_A, 7'h55);
        write_reg(REG_SPARE_B, 7'h2A);
        set_circle('0, '0);
        send_cmd(1'b0, 0);
        send_cmd(1'b1, 0);

        // count past the build size saturates, stride wraps round the circle
        pause_for_idle();
        set_circle('1, '1);
        send_cmd(1'b1, 0);
        send_cmd(1'b0, 0);
        send_cmd(1'b0, 0);

        // stride change in the middle of a running order
        pause_for_idle();
        set_circle(CFG_W'(MAX_PEOPLE), CFG_W'(MAX_PEOPLE));
        send_cmd(1'b0, 0);
        send_cmd(1'b1, 0);
        send_cmd(1'b0, 0);

        pause_for_idle();
        set_circle(CFG_W'(MAX_PEOPLE), CFG_W'(1));
        send_cmd(1'b1, 0);
        send_cmd(1'b0, 0);

        // full short order, then a plain command after the last word restarts it
        pause_for_idle();
        set_circle(CFG_W'(3), CFG_W'(2));
        send_cmd(1'b1, 0);
        send_cmd(1'b0, 0);
        send_cmd(1'b0, 0);
        send_cmd(1'b0, 0);

        // restart cutting an order short
        pause_for_idle();
        set_circle(CFG_W'(5), CFG_W'(100));
        send_cmd(1'b1, 0);
        send_cmd(1'b0, 0);
        send_cmd(1'b1, 0);

        // random phases: mostly plain steps through whole orders, a few restarts
        phase = 0;
        while (total_items < ITEM_TARGET) begin
            pause_for_idle();
            random_setting();
            case (phase % 4)
                1:       idle_pct = 74;
                3:       idle_pct = 29;
                default: idle_pct = 0;
            endcase
            phase_len = $urandom_range(5, 80);
            for (int k = 0; k < phase_len; k++) begin
                // now and then let the block drain completely mid-phase
                if ($urandom_range(0, 39) == 0)
                    pause_for_idle();
                if (k == 0)
                    restart = $urandom_range(0, 1);
                else
                    restart = ($urandom_range(0, 19) == 0);
                send_cmd(restart, idle_pct);
            end
            phase++;
        end

        pause_for_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("josephus_order_generator_unit_tb: clean");
        else
            $display("josephus_order_generator_unit_tb: errors");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin : watchdog
        #(LIMIT_NS);
        $display("josephus_order_generator_unit_tb: errors");
        $finish;
    end

endmodule
